// File: hdl/sis_pkg.sv
`timescale 1ns / 1ps

package sis_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 64;
  localparam int POS_W = 8;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT,
    ST_RDWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef struct packed {
    logic                    already_present;
    logic [POS_W-1:0]        position;
    logic                    full_res;
    logic [CNT_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] read_value;
    logic                    index_valid;
  } result_t;

endpackage

// File: hdl/sis_if.sv
`timescale 1ns / 1ps

interface sis_in_if import sis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [VAL_W-1:0] value;
  logic [7:0]              read_index;

  modport source (output valid, kind, value, read_index, input ready);
  modport sink (input valid, kind, value, read_index, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    already_present;
  logic [7:0]              position;
  logic                    full_res;
  logic [8:0]              entry_count;
  logic signed [VAL_W-1:0] read_value;
  logic                    index_valid;

  modport source (output valid, already_present, position, full_res, entry_count,
                  read_value, index_valid, input ready);
  modport sink (input valid, already_present, position, full_res, entry_count,
                read_value, index_valid, output ready);
endinterface

// File: hdl/sorted_integer_set_insert_core.sv
`timescale 1ns / 1ps

// Channel  Role  Payload
// in_ch    sink  kind, value, read_index
// out_ch   src   already_present, position, full_res, entry_count, read_value, index_valid
//
// An add request is taken and binary-searches the entry memory in up to nine probes, each
// a read and a compare, then closes the search. When the value is new and the set is not
// full, the insert moves later entries up one place through the single memory read port
// and write port, or writes the value at once when it goes at the end. The result is then
// handed off. A read request reads the entry memory, or skips the read when the index is
// out of range. Reset is synchronous and empties the set. A stalled result is held in the
// output register while the next request is taken; a second result waits in the core.

module sorted_integer_set_insert_core import sis_pkg::*; (
  input logic clk,
  input logic rst,
  sis_in_if.sink in_ch,
  sis_out_if.source out_ch
);

  logic    res_valid;
  logic    res_taken;
  result_t res;
  result_t out_q;
  logic    out_valid;

  sis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(in_ch.valid),
    .req_ready(in_ch.ready),
    .req_kind (in_ch.kind),
    .req_value(in_ch.value),
    .req_index(in_ch.read_index),
    .res_valid(res_valid),
    .res_taken(res_taken),
    .res      (res)
  );

  assign res_taken = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken && res_valid) begin
      out_q <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.already_present = out_q.already_present;
  assign out_ch.position = out_q.position;
  assign out_ch.full_res = out_q.full_res;
  assign out_ch.entry_count = out_q.entry_count;
  assign out_ch.read_value = out_q.read_value;
  assign out_ch.index_valid = out_q.index_valid;

endmodule

// File: hdl/sis_ram.sv
`timescale 1ns / 1ps

module sis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/sis_cmp.sv
`timescale 1ns / 1ps

module sis_cmp import sis_pkg::*; (
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output cmp_res_t                res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

// File: hdl/sis_ctrl.sv
`timescale 1ns / 1ps

module sis_ctrl import sis_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic                    req_kind,
  input  logic signed [VAL_W-1:0] req_value,
  input  logic [7:0]              req_index,
  output logic                    res_valid,
  input  logic                    res_taken,
  output result_t                 res
);

  state_t state, state_next;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        mid_q;
  logic [CNT_W-1:0]        j;
  logic                    pend;
  logic [IDX_W-1:0]        pend_addr;
  logic signed [VAL_W-1:0] value;
  logic                    found;
  logic                    present;
  logic                    full;
  logic signed [VAL_W-1:0] rval;
  logic                    rvalid;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic [IDX_W-1:0]        rd_addr;
  logic [VAL_W-1:0]        rd_data;
  cmp_res_t                cmp;

  logic                    accept;
  logic                    idx_ok;

  sis_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sis_cmp u_cmp (
    .a  ($signed(rd_data)),
    .b  (value),
    .res(cmp)
  );

  assign mid = lo + ((hi - lo) >> 1);
  assign accept = req_valid && req_ready;
  assign idx_ok = ({{(CNT_W-8){1'b0}}, req_index} < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready = 1'b0;
    res_valid = 1'b0;
    wr_en = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    rd_addr = mid[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        rd_addr = req_index[IDX_W-1:0];
        if (req_valid) begin
          if (req_kind == KIND_ADD) begin
            state_next = ST_PROBE;
          end else if (idx_ok) begin
            state_next = ST_RDWAIT;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_PROBE: begin
        if (lo < hi) begin
          state_next = ST_CMP;
        end else if (found || count == CNT_W'(CAPACITY)) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_CMP: begin
        state_next = ST_PROBE;
      end
      ST_SHIFT: begin
        rd_addr = j[IDX_W-1:0] - IDX_W'(1);
        if (pend) begin
          wr_en = 1'b1;
        end else if (j == lo) begin
          wr_en = 1'b1;
          wr_addr = lo[IDX_W-1:0];
          wr_data = value;
          state_next = ST_OUT;
        end
      end
      ST_RDWAIT: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_taken) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
        end
        ST_SHIFT: begin
          if (j > lo) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          value <= req_value;
          lo <= '0;
          hi <= count;
          found <= 1'b0;
          present <= 1'b0;
          full <= 1'b0;
          rval <= '0;
          rvalid <= 1'b0;
        end
      end
      ST_PROBE: begin
        mid_q <= mid;
        j <= count;
        if (!(lo < hi)) begin
          present <= found;
          full <= !found && (count == CNT_W'(CAPACITY));
        end
      end
      ST_CMP: begin
        if (cmp.lt) begin
          lo <= mid_q + CNT_W'(1);
        end else begin
          hi <= mid_q;
        end
        if (cmp.eq) begin
          found <= 1'b1;
        end
      end
      ST_SHIFT: begin
        if (j > lo) begin
          pend_addr <= j[IDX_W-1:0];
          j <= j - CNT_W'(1);
        end
      end
      ST_RDWAIT: begin
        rval <= $signed(rd_data);
        rvalid <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.already_present = present;
    res.position = POS_W'(lo);
    res.full_res = full;
    res.entry_count = count;
    res.read_value = rval;
    res.index_valid = rvalid;
  end

endmodule

// File: verif/sorted_integer_set_insert_core_test.sv
`timescale 1ns / 1ps

module sorted_integer_set_insert_core_test;
  import sis_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 3000;
  localparam int unsigned LONG_HOLD_AT = 400;
  localparam int unsigned RANDOM_REQUESTS = 1530;
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
    logic [7:0]              read_index;
    int unsigned             gap;
    bit                      drain_first;
  } set_req_t;

  logic clk;
  logic rst;

  sis_in_if in_ch ();
  sis_out_if out_ch ();

  sorted_integer_set_insert_core dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  set_req_t pending[$];
  set_req_t in_flight;
  result_t expected_results[$];
  logic signed [VAL_W-1:0] added_values[$];

  logic signed [VAL_W-1:0] set_entries[CAPACITY];
  int unsigned set_size = 0;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_mode = 1;
  int unsigned receiver_mode = 1;
  int unsigned sink_wait = 0;
  int unsigned hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report($sformatf("result %0d field %s: got %h, want %h", results_seen, field, got, want));
    end
  endtask

  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? 19 : $urandom_range(0, 2);
    endcase
  endfunction

  // Binary search for the first entry not below the value, then shift-insert unless present or full; reads look up.
  function automatic result_t apply_request(set_req_t r);
    result_t res;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    res = '0;
    if (r.kind == KIND_ADD) begin
      lo = 0;
      hi = set_size;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (set_entries[mid] < r.value) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      res.position = POS_W'(lo);
      if (lo < set_size && set_entries[lo] == r.value) begin
        res.already_present = 1'b1;
      end else if (set_size >= CAPACITY) begin
        res.full_res = 1'b1;
      end else begin
        for (i = set_size; i > lo; i--) begin
          set_entries[i] = set_entries[i - 1];
        end
        set_entries[lo] = r.value;
        set_size++;
      end
    end else if (r.read_index < set_size) begin
      res.index_valid = 1'b1;
      res.read_value = set_entries[r.read_index];
    end
    res.entry_count = CNT_W'(set_size);
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: begin
        v = 64'($urandom_range(0, 200));
        v = v - 64'sd100;
      end
      3: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 15));
      4: v = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 15));
      default: begin
        if (added_values.size() != 0) begin
          v = added_values[$urandom_range(0, added_values.size() - 1)];
        end else begin
          v = {$urandom, $urandom};
        end
      end
    endcase
    return v;
  endfunction

  task automatic queue_request(logic kind, logic signed [VAL_W-1:0] value, logic [7:0] idx,
                               bit drain_first);
    set_req_t r;
    r.kind = kind;
    r.value = value;
    r.read_index = idx;
    r.gap = draw_wait(sender_mode);
    r.drain_first = drain_first;
    pending.push_back(r);
    if (kind == KIND_ADD) begin
      added_values.push_back(value);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_request(in_flight));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered request until it is taken.
      end else if (pending.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending[0].drain_first && (in_ch.valid || expected_results.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else if (pending[0].gap != 0) begin
        pending[0].gap = pending[0].gap - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_flight = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= in_flight.kind;
        in_ch.value <= in_flight.value;
        in_ch.read_index <= in_flight.read_index;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result %0d arrived with no request outstanding", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("already_present", 64'(out_ch.already_present),
                      64'(want.already_present));
          check_field("position", 64'(out_ch.position), 64'(want.position));
          check_field("full_res", 64'(out_ch.full_res), 64'(want.full_res));
          check_field("entry_count", 64'(out_ch.entry_count), 64'(want.entry_count));
          check_field("read_value", out_ch.read_value, want.read_value);
          check_field("index_valid", 64'(out_ch.index_valid), 64'(want.index_valid));
        end
        results_seen++;
        if (results_seen % 100 == 0) begin
          receiver_mode = $urandom_range(0, 2);
        end
        sink_wait = draw_wait(receiver_mode);
        if (results_seen == LONG_HOLD_AT) begin
          hold_left = LONG_HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned add_share;
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ADD;
    in_ch.value = '0;
    in_ch.read_index = '0;
    out_ch.ready = 1'b0;

    queue_request(KIND_READ, 64'h0, 8'd0, 1'b0);
    queue_request(KIND_ADD, 64'h0, 8'hff, 1'b0);
    queue_request(KIND_ADD, 64'h8000_0000_0000_0000, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h7fff_ffff_ffff_ffff, 8'hff, 1'b0);
    queue_request(KIND_ADD, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h1, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h7fff_ffff_ffff_ffff, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h8000_0000_0000_0000, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h0, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h8000_0000_0000_0001, 8'h00, 1'b0);
    queue_request(KIND_ADD, 64'h7fff_ffff_ffff_fffe, 8'h00, 1'b0);
    queue_request(KIND_READ, 64'hffff_ffff_ffff_ffff, 8'd0, 1'b0);
    queue_request(KIND_READ, 64'h0, 8'd6, 1'b0);
    queue_request(KIND_READ, 64'h0, 8'd7, 1'b0);
    queue_request(KIND_READ, 64'hffff_ffff_ffff_ffff, 8'd255, 1'b0);
    queue_request(KIND_ADD, 64'h5555_5555_5555_5555, 8'h55, 1'b0);
    queue_request(KIND_ADD, 64'haaaa_aaaa_aaaa_aaaa, 8'haa, 1'b0);
    queue_request(KIND_READ, 64'h0, 8'd8, 1'b0);
    queue_request(KIND_READ, 64'h0, 8'd1, 1'b0);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        sender_mode = $urandom_range(0, 2);
      end
      add_share = (n < 600) ? 45 : 60;
      if ($urandom_range(0, 99) < add_share) begin
        queue_request(KIND_ADD, pick_value(), 8'($urandom_range(0, 255)),
                      n == 0 || n == 800 || n == 1200);
      end else begin
        queue_request(KIND_READ, {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                      n == 0 || n == 800 || n == 1200);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
